>>> design/gcd_pkg.sv
// Shared constants, types and arithmetic helpers for the great-circle block.
`timescale 1ns / 1ps
`default_nettype none
package gcd_pkg;

  localparam int ITERS = 30;
  localparam int SQRT_STEPS = 31;
  localparam int LANES = 5;
  localparam int LATENCY = 99;

  typedef logic signed [33:0] q30_t;
  typedef logic signed [35:0] vec_t;

  localparam logic [31:0] ATAN_TAB [ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721,
    32'd20860, 32'd10430, 32'd5215, 32'd2607, 32'd1303,
    32'd651, 32'd325, 32'd162, 32'd81, 32'd40,
    32'd20, 32'd10, 32'd5, 32'd2, 32'd1
  };

  localparam q30_t CORDIC_GAIN = 34'sd652032874;
  // ceil(2^36 / 45): exact quotient for magnitudes below 2^30
  localparam logic [30:0] RECIP_45 = 31'd1527099484;
  localparam logic [5:0] DIV_45 = 6'd45;
  // 2 * 2*pi*256/1.852 in Q16
  localparam logic [26:0] NM_SCALE_X2 = 27'd113838398;
  localparam logic [15:0] RADIUS_RESET = 16'd6371;
  localparam logic [4:0] HALF_LANES = 5'b01100;

  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  // floor(r * 512 / 45), or floor(r * 256 / 45) for half angles
  function automatic logic [8:0] bang_frac(input logic [5:0] r, input logic half);
    logic [14:0] n;
    logic [45:0] p;
    n = half ? (15'(r) << 8) : (15'(r) << 9);
    p = 46'(n) * 46'(RECIP_45);
    return p[44:36];
  endfunction

endpackage
`default_nettype wire

>>> design/gcd_sincos.sv
// Pipelined rotation CORDIC: sine and cosine of a binary angle, Q30.
`timescale 1ns / 1ps
`default_nettype none
module gcd_sincos (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [31:0]  ang,
  output gcd_pkg::q30_t     sin_o,
  output gcd_pkg::q30_t     cos_o
);

  gcd_pkg::q30_t x_r [gcd_pkg::ITERS];
  gcd_pkg::q30_t y_r [gcd_pkg::ITERS];
  gcd_pkg::q30_t z_r [gcd_pkg::ITERS];
  logic          f_r [gcd_pkg::ITERS];

  logic          flip0;
  logic [31:0]   folded;
  gcd_pkg::q30_t z0;

  always_comb begin
    flip0  = ang[31] ^ ang[30];
    folded = flip0 ? ang + 32'h8000_0000 : ang;
    z0     = 34'(signed'(folded));
  end

  for (genvar i = 0; i < gcd_pkg::ITERS; i++) begin : g_iter
    gcd_pkg::q30_t xi, yi, zi;
    logic          fi;
    gcd_pkg::q30_t at;
    if (i == 0) begin : g_first
      assign xi = gcd_pkg::CORDIC_GAIN;
      assign yi = '0;
      assign zi = z0;
      assign fi = flip0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = f_r[i-1];
    end
    assign at = 34'(gcd_pkg::ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[33]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - at;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + at;
        end
        f_r[i] <= fi;
      end
    end
  end

  assign sin_o = f_r[gcd_pkg::ITERS-1] ? -y_r[gcd_pkg::ITERS-1] : y_r[gcd_pkg::ITERS-1];
  assign cos_o = f_r[gcd_pkg::ITERS-1] ? -x_r[gcd_pkg::ITERS-1] : x_r[gcd_pkg::ITERS-1];

endmodule
`default_nettype wire

>>> design/gcd_isqrt.sv
// Pipelined floor square root of a Q30 value shifted up by 30 bits.
`timescale 1ns / 1ps
`default_nettype none
module gcd_isqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [30:0] val,
  output logic      [30:0] root
);

  logic [61:0] v_r [gcd_pkg::SQRT_STEPS];
  logic [61:0] r_r [gcd_pkg::SQRT_STEPS];

  for (genvar i = 0; i < gcd_pkg::SQRT_STEPS; i++) begin : g_step
    logic [61:0] vi, ri, trial;
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
    if (i == 0) begin : g_first
      assign vi = {1'b0, val, 30'b0};
      assign ri = '0;
    end else begin : g_next
      assign vi = v_r[i-1];
      assign ri = r_r[i-1];
    end
    assign trial = ri + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= trial) begin
          v_r[i] <= vi - trial;
          r_r[i] <= (ri >> 1) + BIT;
        end else begin
          v_r[i] <= vi;
          r_r[i] <= ri >> 1;
        end
      end
    end
  end

  assign root = r_r[gcd_pkg::SQRT_STEPS-1][30:0];

endmodule
`default_nettype wire

>>> design/gcd_atan2.sv
// Pipelined vectoring CORDIC: atan2(y, x) as a binary angle.
`timescale 1ns / 1ps
`default_nettype none
module gcd_atan2 (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire gcd_pkg::vec_t y,
  input  wire gcd_pkg::vec_t x,
  output gcd_pkg::q30_t      ang
);

  gcd_pkg::vec_t x_r [gcd_pkg::ITERS];
  gcd_pkg::vec_t y_r [gcd_pkg::ITERS];
  gcd_pkg::q30_t z_r [gcd_pkg::ITERS];

  gcd_pkg::vec_t x0, y0;
  gcd_pkg::q30_t z0;

  always_comb begin
    if (x[35]) begin
      x0 = -x;
      y0 = -y;
      z0 = 34'sh0_8000_0000;
    end else begin
      x0 = x;
      y0 = y;
      z0 = '0;
    end
  end

  for (genvar i = 0; i < gcd_pkg::ITERS; i++) begin : g_iter
    gcd_pkg::vec_t xi, yi;
    gcd_pkg::q30_t zi, at;
    if (i == 0) begin : g_first
      assign xi = x0;
      assign yi = y0;
      assign zi = z0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    assign at = 34'(gcd_pkg::ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[35]) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + at;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - at;
        end
      end
    end
  end

  assign ang = z_r[gcd_pkg::ITERS-1];

endmodule
`default_nettype wire

>>> design/great_circle_distance_bearing.sv
// Great-circle distance and initial bearing, fully pipelined haversine datapath.
// Pipeline: 99 register stages.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and stalled.
// Reset (synchronous): all valid bits clear, earth radius returns to 6371 km.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance_bearing (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [27:0] start_lat,
  input  wire logic signed [28:0] start_lon,
  input  wire logic signed [27:0] end_lat,
  input  wire logic signed [28:0] end_lon,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [23:0] range_nm,
  output logic             [24:0] bearing_deg,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [15:0] cfg_radius
);

  localparam int SAME_DEPTH = gcd_pkg::ITERS + 5;
  localparam int ZERO_DEPTH = gcd_pkg::SQRT_STEPS + gcd_pkg::ITERS;

  typedef struct packed {
    logic signed [34:0] bx;
    gcd_pkg::q30_t      by;
  } bvec_t;

  logic        adv;
  logic [15:0] radius;
  logic        vld [gcd_pkg::LATENCY];

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[gcd_pkg::LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < gcd_pkg::LATENCY; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < gcd_pkg::LATENCY; k++) vld[k] <= vld[k-1];
    end
  end

  // angle conversion to binary angles
  logic signed [29:0] n [gcd_pkg::LANES];
  logic        [29:0] mag1 [gcd_pkg::LANES];
  logic               sgn1 [gcd_pkg::LANES];
  logic        [29:0] mag2 [gcd_pkg::LANES];
  logic               sgn2 [gcd_pkg::LANES];
  logic        [24:0] quo2 [gcd_pkg::LANES];
  logic        [31:0] bang [gcd_pkg::LANES];
  logic               same_pipe [SAME_DEPTH];

  always_comb begin
    n[0] = 30'(start_lat);
    n[1] = 30'(end_lat);
    n[2] = 30'(end_lat) - 30'(start_lat);
    n[3] = 30'(end_lon) - 30'(start_lon);
    n[4] = n[3];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      same_pipe[0] <= (start_lat == end_lat) && (start_lon == end_lon);
      for (int k = 1; k < SAME_DEPTH; k++) same_pipe[k] <= same_pipe[k-1];
      for (int k = 0; k < gcd_pkg::LANES; k++) begin
        sgn1[k] <= n[k][29];
        mag1[k] <= n[k][29] ? 30'(-n[k]) : 30'(n[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [60:0] p;
    if (adv) begin
      for (int k = 0; k < gcd_pkg::LANES; k++) begin
        p = 61'(mag1[k]) * 61'(gcd_pkg::RECIP_45);
        quo2[k] <= p[60:36];
        mag2[k] <= mag1[k];
        sgn2[k] <= sgn1[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [29:0] rem;
    logic [31:0] val;
    if (adv) begin
      for (int k = 0; k < gcd_pkg::LANES; k++) begin
        rem = mag2[k] - 30'(quo2[k]) * 30'(gcd_pkg::DIV_45);
        if (gcd_pkg::HALF_LANES[k]) begin
          val = 32'({quo2[k], 8'b0}) + 32'(gcd_pkg::bang_frac(rem[5:0], 1'b1));
        end else begin
          val = 32'({quo2[k], 9'b0}) + 32'(gcd_pkg::bang_frac(rem[5:0], 1'b0));
        end
        bang[k] <= sgn2[k] ? 32'(0) - val : val;
      end
    end
  end

  gcd_pkg::q30_t sn [gcd_pkg::LANES];
  gcd_pkg::q30_t cs [gcd_pkg::LANES];

  for (genvar g = 0; g < gcd_pkg::LANES; g++) begin : g_trig
    gcd_sincos u_sincos (
      .clk   (clk),
      .en    (adv),
      .ang   (bang[g]),
      .sin_o (sn[g]),
      .cos_o (cs[g])
    );
  end

  // products
  gcd_pkg::q30_t p_lat, c12, p_lon, s1c2, c1s2, by1, cd1;
  gcd_pkg::q30_t p_lat2, hav2, t2, c1s2_2, by2;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lat <= gcd_pkg::mul30(sn[2], sn[2]);
      c12   <= gcd_pkg::mul30(cs[0], cs[1]);
      p_lon <= gcd_pkg::mul30(sn[3], sn[3]);
      s1c2  <= gcd_pkg::mul30(sn[0], cs[1]);
      c1s2  <= gcd_pkg::mul30(cs[0], sn[1]);
      by1   <= gcd_pkg::mul30(sn[4], cs[1]);
      cd1   <= cs[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hav2   <= gcd_pkg::mul30(c12, p_lon);
      t2     <= gcd_pkg::mul30(s1c2, cd1);
      p_lat2 <= p_lat;
      c1s2_2 <= c1s2;
      by2    <= by1;
    end
  end

  logic signed [34:0] a_sum, bx_c;
  logic        [30:0] a_cl, a_q, b_q;
  bvec_t              b_vec;
  logic               zero3;

  always_comb begin
    a_sum = 35'(p_lat2) + 35'(hav2);
    if (a_sum[34]) begin
      a_cl = '0;
    end else if (a_sum > 35'sd1073741824) begin
      a_cl = 31'h4000_0000;
    end else begin
      a_cl = a_sum[30:0];
    end
    bx_c = 35'(c1s2_2) - 35'(t2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_q      <= a_cl;
      b_q      <= 31'h4000_0000 - a_cl;
      b_vec.bx <= bx_c;
      b_vec.by <= by2;
      zero3    <= same_pipe[SAME_DEPTH-1] || (bx_c == '0 && by2 == '0);
    end
  end

  // central angle
  logic [30:0] ra, rb;

  gcd_isqrt u_sqrt_a (.clk(clk), .en(adv), .val(a_q), .root(ra));
  gcd_isqrt u_sqrt_b (.clk(clk), .en(adv), .val(b_q), .root(rb));

  bvec_t bpipe [gcd_pkg::SQRT_STEPS];
  logic  zpipe [ZERO_DEPTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      bpipe[0] <= b_vec;
      zpipe[0] <= zero3;
      for (int k = 1; k < gcd_pkg::SQRT_STEPS; k++) bpipe[k] <= bpipe[k-1];
      for (int k = 1; k < ZERO_DEPTH; k++) zpipe[k] <= zpipe[k-1];
    end
  end

  gcd_pkg::q30_t zc, zb;

  gcd_atan2 u_atan_dist (
    .clk (clk),
    .en  (adv),
    .y   (36'(ra)),
    .x   (36'(rb)),
    .ang (zc)
  );

  gcd_atan2 u_atan_bear (
    .clk (clk),
    .en  (adv),
    .y   (36'(bpipe[gcd_pkg::SQRT_STEPS-1].by)),
    .x   (36'(bpipe[gcd_pkg::SQRT_STEPS-1].bx)),
    .ang (zb)
  );

  // scaling
  logic [30:0] zc_cl;
  logic [32:0] t_nm;
  logic [24:0] bear1;

  always_comb begin
    if (zc[33]) begin
      zc_cl = '0;
    end else if (zc > 34'sd1073741824) begin
      zc_cl = 31'h4000_0000;
    end else begin
      zc_cl = zc[30:0];
    end
  end

  always_ff @(posedge clk) begin
    logic [57:0] pt;
    logic [40:0] pb;
    if (adv) begin
      pt    = 58'(zc_cl) * 58'(gcd_pkg::NM_SCALE_X2);
      pb    = 41'(zb[31:0]) * 41'(360);
      t_nm  <= pt[56:24];
      bear1 <= zpipe[ZERO_DEPTH-1] ? '0 : pb[40:16];
    end
  end

  always_ff @(posedge clk) begin
    logic [49:0] pd;
    if (adv) begin
      pd = 50'(t_nm) * 50'(radius) + 50'(24'h80_0000);
      range_nm    <= (pd[49:48] != 2'b00) ? 24'hFF_FFFF : pd[47:24];
      bearing_deg <= bear1;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the great-circle distance and bearing block.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int ANG_FRAC = 20;
  localparam int NROUTES = 550;
  localparam int WATCHDOG = 5000;
  localparam int DRAIN = gcd_pkg::LATENCY + 20;
  localparam longint LAT_LIM = 94371840;
  localparam longint LON_LIM = 188743680;

  localparam longint ATAN_STEP [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162,
    81, 40, 20, 10, 5, 2, 1
  };

  typedef struct packed {
    logic [23:0] rng;
    logic [24:0] bear;
  } nav_fix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [27:0] start_lat = '0;
  logic signed [28:0] start_lon = '0;
  logic signed [27:0] end_lat = '0;
  logic signed [28:0] end_lon = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [23:0] range_nm;
  logic [24:0] bearing_deg;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_radius = '0;

  bit failed = 1'b0;
  bit calm = 1'b0;
  int idle_cnt = 0;

  great_circle_distance_bearing dut (.*);

  function automatic longint floor_shr(longint v, int s);
    return (v >= 0) ? (v >>> s) : -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor_shr(a * b, 30);
  endfunction

  function automatic longint bin_angle(longint deg, longint turn);
    longint q;
    logic [31:0] w;
    q = (deg * 64'sd4294967296) / (turn * (64'sd1 << ANG_FRAC));
    w = q[31:0];
    return longint'(w);
  endfunction

  function automatic void sin_cos(longint ang, output longint s, output longint c);
    logic [31:0] a;
    bit flip;
    longint x, y, z, xs, ys;
    a = ang[31:0];
    flip = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) a = a + 32'h8000_0000;
    z = a[31] ? longint'(a) - 64'sd4294967296 : longint'(a);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_STEP[i];
      end else begin
        x += ys; y -= xs; z += ATAN_STEP[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint arc_tan2(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd2147483648;
    end
    for (int i = 0; i < 30; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_STEP[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic void plot_route(longint lat1, longint lon1, longint lat2, longint lon2,
                                     longint radius, output nav_fix_t fix);
    longint s1, c1, s2, c2, shl, chl, sho, cho, sd, cd;
    longint a, bx, by, zc, ra, rb;
    longint unsigned t, d, zb;
    sin_cos(bin_angle(lat1, 360), s1, c1);
    sin_cos(bin_angle(lat2, 360), s2, c2);
    sin_cos(bin_angle(lat2 - lat1, 720), shl, chl);
    sin_cos(bin_angle(lon2 - lon1, 720), sho, cho);
    sin_cos(bin_angle(lon2 - lon1, 360), sd, cd);
    a = qmul(shl, shl) + qmul(qmul(c1, c2), qmul(sho, sho));
    if (a < 0) a = 0;
    if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
    ra = int_sqrt(longint'(a) << 30);
    rb = int_sqrt(((64'sd1 << 30) - a) << 30);
    zc = arc_tan2(ra, rb);
    if (zc < 0) zc = 0;
    if (zc > (64'sd1 << 30)) zc = 64'sd1 << 30;
    t = (longint'(zc) * 2 * 56919199) >> 24;
    d = (t * radius + (64'd1 << 23)) >> 24;
    if (d > 16777215) d = 16777215;
    fix.rng = d[23:0];
    by = qmul(sd, c2);
    bx = qmul(c1, s2) - qmul(qmul(s1, c2), cd);
    if ((lat1 == lat2 && lon1 == lon2) || (bx == 0 && by == 0)) fix.bear = '0;
    else begin
      zb = arc_tan2(by, bx) & 64'hFFFF_FFFF;
      zb = (zb * 360) >> 16;
      fix.bear = zb[24:0];
    end
  endfunction

  class route_board;
    nav_fix_t pending[$];
    longint radius = gcd_pkg::RADIUS_RESET;

    function void note_request(longint la1, longint lo1, longint la2, longint lo2);
      nav_fix_t f;
      plot_route(la1, lo1, la2, lo2, radius, f);
      pending.push_back(f);
    endfunction

    function void check_fix(logic [23:0] d, logic [24:0] b);
      nav_fix_t e;
      if (pending.size() == 0) begin
        $error("unexpected result range=%0d bear=%0d", d, b);
        failed = 1'b1;
        return;
      end
      e = pending.pop_front();
      if (d !== e.rng) begin
        $error("range_nm expected %0d actual %0d", e.rng, d);
        failed = 1'b1;
      end
      if (b !== e.bear) begin
        $error("bearing_deg expected %0d actual %0d", e.bear, b);
        failed = 1'b1;
      end
    endfunction
  endclass

  route_board board = new();

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_fix(range_nm, bearing_deg);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WATCHDOG) begin
        $display("great_circle_distance_bearing verification failed");
        $finish;
      end
    end
  end

  // receiver stalls in short bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send_route(longint la1, longint lo1, longint la2, longint lo2);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_lat <= la1[27:0];
    start_lon <= lo1[28:0];
    end_lat <= la2[27:0];
    end_lon <= lo2[28:0];
    do @(posedge clk); while (in_stall);
    board.note_request(longint'(start_lat), longint'(start_lon),
                       longint'(end_lat), longint'(end_lon));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_radius(longint r);
    cfg_valid <= 1'b1;
    cfg_radius <= r[15:0];
    do @(posedge clk); while (!cfg_ready);
    board.radius = r;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic longint any_bits(int w);
    longint v;
    v = {$urandom(), $urandom()};
    return floor_shr(v <<< (64 - w), 64 - w);
  endfunction

  task automatic random_route();
    longint la1, lo1, la2, lo2;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      la1 = any_bits(28); lo1 = any_bits(29); la2 = any_bits(28); lo2 = any_bits(29);
    end else if (k == 1) begin
      la1 = $urandom_range(0, 2 * LAT_LIM) - LAT_LIM;
      lo1 = $urandom_range(0, 2 * LON_LIM) - LON_LIM;
      la2 = la1 + $urandom_range(0, 2000) - 1000;
      lo2 = lo1 + $urandom_range(0, 2000) - 1000;
    end else begin
      la1 = $urandom_range(0, 2 * LAT_LIM) - LAT_LIM;
      lo1 = $urandom_range(0, 2 * LON_LIM) - LON_LIM;
      la2 = $urandom_range(0, 2 * LAT_LIM) - LAT_LIM;
      lo2 = $urandom_range(0, 2 * LON_LIM) - LON_LIM;
    end
    send_route(la1, lo1, la2, lo2);
  endtask

  initial begin
    longint deg;
    deg = 64'sd1 << ANG_FRAC;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset radius, directed cases
    send_route(0, 0, 0, 0);
    send_route(LAT_LIM, 0, -LAT_LIM, 0);
    send_route(0, -LON_LIM, 0, LON_LIM);
    send_route(0, 0, 0, 180 * deg);
    send_route(0, 0, 0, 90 * deg);
    send_route(LAT_LIM, 5 * deg, 10 * deg, 20 * deg);
    send_route(-LAT_LIM, 0, 0, 0);
    send_route(51 * deg, 0, 40 * deg, -74 * deg);
    send_route(10 * deg, 10 * deg, 10 * deg, 10 * deg);
    send_route(-(64'sd1 << 27), -(64'sd1 << 28), (64'sd1 << 27) - 1, (64'sd1 << 28) - 1);
    send_route((64'sd1 << 27) - 1, (64'sd1 << 28) - 1, -(64'sd1 << 27), -(64'sd1 << 28));
    send_route(0, 0, 1, 0);
    send_route(0, 0, 0, -1);
    send_route(-1, -1, -1, -1);
    settle();
    set_radius(65535);
    send_route(0, 0, 0, 180 * deg);
    send_route(LAT_LIM, 0, -LAT_LIM, 0);
    send_route(0, 0, 30 * deg, 45 * deg);
    settle();
    set_radius(0);
    send_route(0, 0, 30 * deg, 45 * deg);
    settle();
    set_radius(1);
    send_route(0, 0, 0, 180 * deg);
    send_route(0, 0, 30 * deg, 45 * deg);
    settle();
    for (int ph = 0; ph < 5; ph++) begin
      set_radius(ph == 4 ? 6371 : $urandom_range(1, 65535));
      if (ph == 4) calm = 1'b1;
      repeat (NROUTES / 5) random_route();
      settle();
    end
    repeat (DRAIN) @(posedge clk);
    if (failed || board.pending.size() != 0)
      $display("great_circle_distance_bearing verification failed");
    else
      $display("great_circle_distance_bearing verification clean");
    $finish;
  end
endmodule
`default_nettype wire
